[rtl/pstg_pkg.sv]
//------------------------------------------------------------------------------
// pstg_pkg
// Shared types, widths and the quarter-wave sine table builder.
//------------------------------------------------------------------------------
`default_nettype none
package pstg_pkg;

   localparam int POS_W  = 40;
   localparam int LEN_W  = 39;
   localparam int RATE_W = 20;

   // register indexes of the csr port
   localparam logic CSR_SAMPLE_RATE   = 1'b0;
   localparam logic CSR_SIGNAL_LENGTH = 1'b1;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] TAYLOR_DIV [9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210, 64'd272, 64'd342};

   // classified beat handed from front to back
   typedef struct packed {
      logic [LEN_W-1:0] pos;
      logic             zero;
   } item_type;

   // sin(pi*k/2^(tbits-1)) in Q(obits-1), evaluated at elaboration
   function automatic logic [63:0] quarter_sine(input int k, input int tbits,
                                                input int obits);
      logic [63:0] pi40;
      logic [63:0] kk;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] fs;
      longint      sum;
      int          ash;
      pi40 = PI_Q60 >> 20;
      kk   = 64'(k);
      ash  = 10 + tbits - 1;
      x    = (kk * pi40 + (64'd1 << (ash - 1))) >> ash;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      s  = (sum < 0) ? 64'd0 : 64'(sum);
      fs = (64'd1 << (obits - 1)) - 64'd1;
      v  = ((s << 32) + (64'd1 << (62 - obits))) >> (63 - obits);
      if (v > fs) begin
         v = fs;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/pstg_div.sv]
//------------------------------------------------------------------------------
// pstg_div
// Pipelined restoring divider, one quotient bit per stage. The caller must hold
// the divisor steady while beats are in flight; the divider does not enforce it.
//------------------------------------------------------------------------------
`default_nettype none
module pstg_div #(
   parameter int NUM_W  = 39,
   parameter int DEN_W  = 21,
   parameter int Q_W    = 1,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [DEN_W-1:0]       out_rem,
   output logic [Q_W-1:0]         out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [Q_W-1:0]    quo_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              valid_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [Q_W-1:0]    quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [Q_W:0]      quo_wide;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign num_prev   = in_num;
         assign quo_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign num_prev   = num_ff[s-1];
         assign quo_prev   = quo_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      always_comb begin
         trial    = {rem_prev, num_prev[NUM_W-1]};
         ge       = (trial >= {1'b0, in_den});
         rem_in   = ge ? DEN_W'(trial - {1'b0, in_den}) : DEN_W'(trial);
         quo_wide = {quo_prev, ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_prev;
         end
         rem_ff[s]  <= rem_in;
         num_ff[s]  <= num_prev << 1;
         quo_ff[s]  <= quo_wide[Q_W-1:0];
         side_ff[s] <= side_prev;
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule
`default_nettype wire

[rtl/pstg_front.sv]
//------------------------------------------------------------------------------
// pstg_front
// Accepts requests and flags the ones that render as silence (negative or
// past the signal end).
//------------------------------------------------------------------------------
`default_nettype none
module pstg_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pstg_pkg::POS_W-1:0]    req_sample_position,
   input  wire logic [pstg_pkg::LEN_W-1:0]    signal_length,
   input  wire logic                          queue_full,
   output logic                               busy,
   output logic                               push,
   output pstg_pkg::item_type                 push_item
);

   logic               valid_ff;
   logic               valid_in;
   pstg_pkg::item_type item_ff;
   pstg_pkg::item_type item_in;
   logic               accept;

   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;
   assign push   = valid_ff && !queue_full;

   always_comb begin
      valid_in     = accept || (valid_ff && queue_full);
      item_in      = item_ff;
      if (accept) begin
         item_in.pos  = req_sample_position[pstg_pkg::LEN_W-1:0];
         item_in.zero = req_sample_position[pstg_pkg::POS_W-1] ||
                        (req_sample_position[pstg_pkg::LEN_W-1:0] >= signal_length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_item = item_ff;

endmodule
`default_nettype wire

[rtl/pstg_queue.sv]
//------------------------------------------------------------------------------
// pstg_queue
// Two-entry queue between front and back.
//------------------------------------------------------------------------------
`default_nettype none
module pstg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pstg_pkg::item_type push_item,
   input  wire logic               pop_ready,
   output logic                    full,
   output logic                    pop,
   output pstg_pkg::item_type      pop_item
);

   pstg_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign pop      = (count_ff != 2'd0) && pop_ready;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not advance");

endmodule
`default_nettype wire

[rtl/pstg_back.sv]
//------------------------------------------------------------------------------
// pstg_back
// Gate, level and phase arithmetic: three pipelined dividers, then the
// quarter-wave table lookup and sign.
//------------------------------------------------------------------------------
`default_nettype none
module pstg_back #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_BITS        = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire pstg_pkg::item_type           in_item,
   input  wire logic [pstg_pkg::RATE_W-1:0]  rate,
   output logic                              out_valid,
   output logic [OUT_BITS-1:0]               out_value
);

   localparam int T     = SINE_TABLE_BITS;
   localparam int RW    = pstg_pkg::RATE_W;
   localparam int QTR   = 1 << (T - 2);
   localparam int PW    = RW + 9;
   localparam int NW3   = RW + T + 1;
   localparam logic [T-2:0] QTR_IDX = (T-1)'(QTR);

   logic [OUT_BITS-1:0] sine_tab [QTR+1];
   for (genvar k = 0; k <= QTR; k++) begin : g_tab
      assign sine_tab[k] = OUT_BITS'(pstg_pkg::quarter_sine(k, T, OUT_BITS));
   end

   // p mod 2*rate
   logic          d1_valid;
   logic [RW:0]   d1_rem;
   logic          d1_quo;
   logic          d1_zero;

   pstg_div #(.NUM_W(pstg_pkg::LEN_W), .DEN_W(RW + 1), .Q_W(1), .SIDE_W(1)) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_num   (in_item.pos),
      .in_den   ({rate, 1'b0}),
      .in_side  (in_item.zero),
      .out_valid(d1_valid),
      .out_rem  (d1_rem),
      .out_quo  (d1_quo),
      .out_side (d1_zero)
   );

   // fold to p mod rate, gate and level
   logic          a_valid_ff;
   logic [RW-1:0] a_m_ff, a_m_in;
   logic          a_full_ff, a_zero_ff, a_full_in, a_zero_in;

   always_comb begin
      a_m_in    = (d1_rem >= {1'b0, rate}) ? RW'(d1_rem - {1'b0, rate}) : RW'(d1_rem);
      a_full_in = (d1_rem <= {1'b0, rate});
      a_zero_in = d1_zero || ({a_m_in, 1'b0} > {1'b0, rate});
   end

   // scale by 440
   logic          b_valid_ff;
   logic [PW-1:0] b_prod_ff;
   logic          b_full_ff, b_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= d1_valid;
         b_valid_ff <= a_valid_ff;
      end
      a_m_ff    <= a_m_in;
      a_full_ff <= a_full_in;
      a_zero_ff <= a_zero_in;
      b_prod_ff <= PW'(a_m_ff) * PW'(440);
      b_full_ff <= a_full_ff;
      b_zero_ff <= a_zero_ff;
   end

   // (p*440) mod rate
   logic          d2_valid;
   logic [RW-1:0] d2_rem;
   logic          d2_quo;
   logic [1:0]    d2_side;

   pstg_div #(.NUM_W(PW), .DEN_W(RW), .Q_W(1), .SIDE_W(2)) u_div2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_valid_ff),
      .in_num   (b_prod_ff),
      .in_den   (rate),
      .in_side  ({b_zero_ff, b_full_ff}),
      .out_valid(d2_valid),
      .out_rem  (d2_rem),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // rounded table index numerator
   logic           c_valid_ff;
   logic [NW3-1:0] c_num_ff;
   logic [1:0]     c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= d2_valid;
      end
      c_num_ff  <= {1'b0, d2_rem, {T{1'b0}}} + NW3'(rate[RW-1:1]);
      c_side_ff <= d2_side;
   end

   logic          d3_valid;
   logic [RW-1:0] d3_rem;
   logic [T-1:0]  d3_idx;
   logic [1:0]    d3_side;

   pstg_div #(.NUM_W(NW3), .DEN_W(RW), .Q_W(T), .SIDE_W(2)) u_div3 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_valid_ff),
      .in_num   (c_num_ff),
      .in_den   (rate),
      .in_side  (c_side_ff),
      .out_valid(d3_valid),
      .out_rem  (d3_rem),
      .out_quo  (d3_idx),
      .out_side (d3_side)
   );

   // quadrant mirror, table, level and sign
   logic                out_valid_ff;
   logic [OUT_BITS-1:0] out_value_ff, out_value_in;
   logic [1:0]          quad;
   logic [T-2:0]        sel;
   logic [OUT_BITS-1:0] mag;

   always_comb begin
      quad = d3_idx[T-1:T-2];
      sel  = quad[0] ? (QTR_IDX - {1'b0, d3_idx[T-3:0]}) : {1'b0, d3_idx[T-3:0]};
      mag  = sine_tab[sel];
      if (!d3_side[0]) begin
         mag = mag >> 3;
      end
      if (d3_side[1]) begin
         out_value_in = '0;
      end else if (quad[1]) begin
         out_value_in = OUT_BITS'(-mag);
      end else begin
         out_value_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= d3_valid;
      end
      out_value_ff <= out_value_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

   a_rem_lt_rate: assert property (@(posedge clock) disable iff (reset)
      d2_valid |-> (d2_rem < rate)) else $error("phase remainder out of range");
   a_fold_lt_rate: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (a_m_ff < rate)) else $error("folded position out of range");
   a_zero_silent: assert property (@(posedge clock) disable iff (reset)
      (d3_valid && d3_side[1]) |=> (out_value_ff == '0)) else $error("gated beat not silent");

endmodule
`default_nettype wire

[rtl/pulsed_sine_tone_generator.sv]
//------------------------------------------------------------------------------
// pulsed_sine_tone_generator
// Gated 440 Hz sine source: one Q1.(OUT_BITS-1) sample per request.
//
//  channel  ports                                   dir  handshake
//  request  start, busy, req_sample_position        in   start && !busy
//  result   rsp_valid, rsp_sample_value             out  one-cycle strobe
//  csr      csr_we, csr_index, csr_wdata            in   write when csr_we
//
// One request per cycle sustained; busy stays low in normal operation.
// An accepted request reaches the result through three bit-per-stage divider
// pipelines (39, 29 and 21+SINE_TABLE_BITS stages) plus front, queue and four
// arithmetic registers.
// Synchronous active-high reset; no clearing pass, the sine table is constant.
// The result side has no stall: each beat shows for exactly one cycle.
//------------------------------------------------------------------------------
`default_nettype none
module pulsed_sine_tone_generator #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_BITS        = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [pstg_pkg::POS_W-1:0]   req_sample_position,
   output logic                              rsp_valid,
   output logic [OUT_BITS-1:0]               rsp_sample_value,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [pstg_pkg::LEN_W-1:0]   csr_wdata
);

   logic [pstg_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [pstg_pkg::LEN_W-1:0]  length_ff, length_in;
   logic [pstg_pkg::RATE_W-1:0] rate_eff;

   always_comb begin
      rate_in   = rate_ff;
      length_in = length_ff;
      if (csr_we) begin
         case (csr_index)
            pstg_pkg::CSR_SAMPLE_RATE:   rate_in   = csr_wdata[pstg_pkg::RATE_W-1:0];
            pstg_pkg::CSR_SIGNAL_LENGTH: length_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= pstg_pkg::RATE_RESET;
         length_ff <= '0;
      end else begin
         rate_ff   <= rate_in;
         length_ff <= length_in;
      end
   end

   // a zero rate behaves as one
   assign rate_eff = (rate_ff == '0) ? pstg_pkg::RATE_W'(1) : rate_ff;

   logic               queue_full;
   logic               push;
   pstg_pkg::item_type push_item;
   logic               pop;
   pstg_pkg::item_type pop_item;

   pstg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_sample_position(req_sample_position),
      .signal_length      (length_ff),
      .queue_full         (queue_full),
      .busy               (busy),
      .push               (push),
      .push_item          (push_item)
   );

   pstg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop_ready(1'b1),
      .full     (queue_full),
      .pop      (pop),
      .pop_item (pop_item)
   );

   pstg_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS), .OUT_BITS(OUT_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pop),
      .in_item  (pop_item),
      .rate     (rate_eff),
      .out_valid(rsp_valid),
      .out_value(rsp_sample_value)
   );

endmodule
`default_nettype wire

[sim/tb_pulsed_sine_tone_generator.sv]
//------------------------------------------------------------------------------
// tb_pulsed_sine_tone_generator
// Drives sample positions through several rate/length settings and idle
// mixes, predicts every sample with an independent table-based model, and
// checks each result beat in order against the oldest prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class tone_scoreboard;
   localparam int TAB_BITS = 10;
   localparam int QTR      = 1 << (TAB_BITS - 2);

   logic [63:0]      quarter_mag [QTR+1];
   logic [19:0]      rate_reg;
   logic [38:0]      length_reg;
   logic [23:0]      expected_samples [$];
   logic [39:0]      expected_pos [$];
   int               errors;
   int               checked;
   int               sounding;

   function new();
      logic [63:0] pi40;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] v;
      longint      acc;
      pi40 = 64'h3243F6A8885A308D >> 20;
      for (int k = 0; k <= QTR; k++) begin
         x    = (64'(k) * pi40 + (64'd1 << (TAB_BITS + 8))) >> (TAB_BITS + 9);
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
         end
         s = (acc < 0) ? 64'd0 : 64'(acc);
         v = ((s << 32) + (64'd1 << 38)) >> 39;
         if (v > 64'h7F_FFFF) v = 64'h7F_FFFF;
         quarter_mag[k] = v;
      end
      rate_reg   = 20'd48000;
      length_reg = '0;
      errors     = 0;
      checked    = 0;
      sounding   = 0;
   endfunction

   function void write_reg(logic idx, logic [38:0] data);
      if (idx == pstg_pkg::CSR_SAMPLE_RATE) rate_reg = data[19:0];
      else length_reg = data;
   endfunction

   function logic [23:0] tone_sample(logic [39:0] pos);
      logic [63:0] p;
      logic [63:0] r;
      logic [63:0] ph;
      logic [63:0] idx;
      logic [63:0] mag;
      logic [1:0]  quad;
      int          off;
      p = 64'(pos);
      r = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
      if (pos[39]) return '0;
      if (p >= 64'(length_reg)) return '0;
      if (2 * (p % r) > r) return '0;   // silent half of the second
      ph   = (p * 440) % r;
      idx  = (((ph << TAB_BITS) + r / 2) / r) & ((64'd1 << TAB_BITS) - 1);
      quad = idx[TAB_BITS-1:TAB_BITS-2];
      off  = int'(idx[TAB_BITS-3:0]);
      mag  = quad[0] ? quarter_mag[QTR-off] : quarter_mag[off];
      if ((p % (2 * r)) > r) mag = mag >> 3;   // odd second: one eighth
      return quad[1] ? 24'(-mag) : 24'(mag);
   endfunction

   function void note_position(logic [39:0] pos);
      expected_samples.push_back(tone_sample(pos));
      expected_pos.push_back(pos);
   endfunction

   function void check_sample(logic [23:0] got);
      logic [23:0] exp_val;
      logic [39:0] pos;
      if (expected_samples.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, actual %0d",
                  $time, $signed(got));
         errors++;
         return;
      end
      exp_val = expected_samples.pop_front();
      pos     = expected_pos.pop_front();
      checked++;
      if (exp_val != 0) sounding++;
      if (got !== exp_val) begin
         $display("%0t: sample_value mismatch at position %0d: expected %0d, actual %0d",
                  $time, $signed(pos), $signed(exp_val), $signed(got));
         errors++;
      end
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction
endclass

module tb_pulsed_sine_tone_generator;
   localparam int IDLE_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [39:0] req_sample_position = '0;
   logic        rsp_valid;
   logic [23:0] rsp_sample_value;
   logic        csr_we = 1'b0;
   logic        csr_index = pstg_pkg::CSR_SAMPLE_RATE;
   logic [38:0] csr_wdata = '0;

   tone_scoreboard sb = new();
   int             quiet_cycles = 0;
   int             beats_in = 0;

   pulsed_sine_tone_generator DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample_position(req_sample_position),
      .rsp_valid          (rsp_valid),
      .rsp_sample_value   (rsp_sample_value),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_sample(rsp_sample_value);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, nothing moving", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_csr(logic idx, logic [38:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_we <= 1'b0;
   endtask

   // one beat; gap_pct percent chance of dropping start afterwards
   task automatic send_position(logic [39:0] pos, int gap_pct);
      start               <= 1'b1;
      req_sample_position <= pos;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_position(pos);
      beats_in++;
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [39:0] pick_position();
      logic [63:0] r;
      logic [63:0] len;
      logic [63:0] lim;
      logic [63:0] base;
      r   = (sb.rate_reg == 0) ? 64'd1 : 64'(sb.rate_reg);
      len = 64'(sb.length_reg);
      case ($urandom_range(0, 9))
         0: return 40'({$urandom, $urandom});
         1: return {1'b1, 7'($urandom), $urandom};
         2, 3: begin
            base = 64'($urandom_range(0, 20)) * r;
            case ($urandom_range(0, 5))
               0: return 40'(base);
               1: return 40'(base + r / 2);
               2: return 40'(base + r / 2 + 1);
               3: return 40'(base + r);
               4: return 40'(base + r + 1);
               default: return 40'(base + r - 1);
            endcase
         end
         4: return 40'(len - 64'($urandom_range(0, 2)) + 64'($urandom_range(0, 1)));
         default: begin
            lim = (len < 40 * r) ? len : 40 * r;
            if (lim == 0) return 40'($urandom_range(0, 100));
            return 40'({$urandom, $urandom} % lim);
         end
      endcase
   endfunction

   task automatic run_phase(logic [38:0] rate_word, logic [38:0] length, int gap_pct,
                            int count);
      write_csr(pstg_pkg::CSR_SAMPLE_RATE, rate_word);
      write_csr(pstg_pkg::CSR_SIGNAL_LENGTH, length);
      for (int i = 0; i < count; i++) send_position(pick_position(), gap_pct);
      drain();
   endtask

   initial begin
      logic [39:0] directed [$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: length zero, everything silent
      send_position(40'd0, 0);
      send_position(40'd100, 0);
      drain();

      write_csr(pstg_pkg::CSR_SIGNAL_LENGTH, {39{1'b1}});
      directed = '{40'd0, 40'd1, 40'd23999, 40'd24000, 40'd24001, 40'd47999,
                   40'd48000, 40'd48001, 40'd72000, 40'd72001, 40'd96000,
                   {40{1'b1}}, {1'b1, 39'd0}, {1'b0, {39{1'b1}}},
                   {1'b0, {38{1'b1}}, 1'b0}, 40'd12345, 40'd109};
      foreach (directed[i]) send_position(directed[i], 0);
      drain();
      // length edge
      write_csr(pstg_pkg::CSR_SIGNAL_LENGTH, 39'd1000);
      send_position(40'd999, 0);
      send_position(40'd1000, 0);
      drain();

      run_phase(39'd48000, {39{1'b1}}, 0, 250);
      run_phase(39'd1, 39'd1000, 58, 220);
      run_phase(39'd0, 39'd5000, 0, 150);               // rate zero acts as one
      run_phase(39'd768000, 39'd5000000, 27, 250);
      run_phase({19'h7FFFF, 20'd44100}, {39{1'b1}}, 58, 250); // upper bits ignored
      run_phase(39'd7, 39'd0, 27, 60);
      run_phase({19'd0, 20'hFFFFF}, {39{1'b1}}, 0, 150);
      run_phase(39'd7, {39{1'b1}}, 58, 200);

      repeat (150) @(posedge clock);
      if (sb.pending() > 0) begin
         $display("%0t: %0d expected samples never arrived", $time, sb.pending());
         sb.errors++;
      end
      $display("Covered %0d request beats over 8 rate/length settings, %0d results checked,",
               beats_in, sb.checked);
      $display("%0d of them sounding.", sb.sounding);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

`default_nettype wire
